/* rtl/core/epd_pkg.sv */
// Shared types and constants for the encoded polyline decoder.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
`timescale 1ns / 1ps

package epd_pkg;

  // Default sizing, handed to the top level parameters
  localparam int ACC_WIDTH_DEF      = 48;
  localparam int COORD_FRAC_DEF     = 16;
  localparam int MAX_FRAC_SHIFT_DEF = 16;

  // Fixed field widths
  localparam int FRAC_W = 5;
  localparam int POS_W  = 32;

  // Result kinds
  localparam logic [1:0] KIND_MOVETO  = 2'd0;
  localparam logic [1:0] KIND_LINETO  = 2'd1;
  localparam logic [1:0] KIND_PEN     = 2'd2;
  localparam logic [1:0] KIND_BAD_PEN = 2'd3;

  // Transform coefficients and offsets from the register file
  typedef struct packed {
    logic signed [POS_W-1:0] gain_xx;
    logic signed [POS_W-1:0] gain_xy;
    logic signed [POS_W-1:0] gain_yx;
    logic signed [POS_W-1:0] gain_yy;
    logic signed [POS_W-1:0] offset_x;
    logic signed [POS_W-1:0] offset_y;
  } xform_t;

  // One pipeline command: pen reload, pen select result or coordinate pair
  typedef struct packed {
    logic                    load;      // command start, pen takes start position
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic                    pair;      // coordinate pair to transform
    logic                    absolute;  // pair is absolute (offset base)
    logic                    draw;      // pen down when the pair was decoded
    logic                    pen;       // pen select finished
    logic                    pen_bad;   // pen number out of range
    logic [7:0]              pen_idx;
  } cmd_t;

endpackage

/* rtl/core/epd_decode.sv */
// Byte decoder: flag bytes, base-64/base-32 number accumulation and coordinate scaling.
// Holds all per-command decode state; one byte per cycle into a command register, unless it is full and stalled.
// Depends on epd_pkg.
`timescale 1ns / 1ps

module epd_decode #(
  parameter int ACC_WIDTH      = epd_pkg::ACC_WIDTH_DEF,
  parameter int COORD_FRAC     = epd_pkg::COORD_FRAC_DEF,
  parameter int MAX_FRAC_SHIFT = epd_pkg::MAX_FRAC_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      code_byte,
  input  logic                            first,
  input  logic signed [epd_pkg::POS_W-1:0] start_x,
  input  logic signed [epd_pkg::POS_W-1:0] start_y,
  input  logic [8:0]                      pen_limit,
  input  logic                            pen_is_down,
  output logic                            slot_valid,
  input  logic                            slot_ready,
  output epd_pkg::cmd_t                   slot_cmd,
  output logic signed [epd_pkg::POS_W-1:0] slot_x,
  output logic signed [epd_pkg::POS_W-1:0] slot_y
);

  localparam int HALF_W = ACC_WIDTH - 1;
  localparam int FM1    = COORD_FRAC - 1;
  localparam int FW     = epd_pkg::FRAC_W;

  // Number target codes
  localparam logic [2:0] TGT_IDLE = 3'd0;
  localparam logic [2:0] TGT_PEN  = 3'd1;
  localparam logic [2:0] TGT_FRAC = 3'd2;
  localparam logic [2:0] TGT_X    = 3'd3;
  localparam logic [2:0] TGT_Y    = 3'd4;

  // Sign codes
  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  // Byte codes
  localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
  localparam logic [7:0] CH_PEN   = 8'h3A;  // ':'
  localparam logic [7:0] CH_MOVE  = 8'h3C;  // '<'
  localparam logic [7:0] CH_ABS   = 8'h3D;  // '='
  localparam logic [7:0] CH_FRAC  = 8'h3E;  // '>'
  localparam logic [7:0] DIGIT_LO = 8'd63;
  localparam logic [7:0] TERM8_LO = 8'd191;
  localparam logic [7:0] TERM8_HI = 8'd254;
  localparam logic [7:0] TERM7_LO = 8'd95;
  localparam logic [7:0] TERM7_HI = 8'd126;

  localparam logic [3:0]  DPOS_MAX = 4'd15;
  localparam logic [8:0]  PEN_MAX  = 9'd256;
  localparam logic [30:0] MAG_LIM  = '1;

  // Decode state
  logic                           seven_bit_mode;
  logic [FW-1:0]                  frac_shift;
  logic                           draw_flag;
  logic                           absolute_flag;
  logic                           aborted;
  logic [2:0]                     number_target;
  logic [ACC_WIDTH-1:0]           accumulator;
  logic [3:0]                     digit_position;
  logic [1:0]                     sign_state;
  logic signed [epd_pkg::POS_W-1:0] held_x;

  logic                           seven_bit_mode_next;
  logic [FW-1:0]                  frac_shift_next;
  logic                           draw_flag_next;
  logic                           absolute_flag_next;
  logic                           aborted_next;
  logic [2:0]                     number_target_next;
  logic [ACC_WIDTH-1:0]           accumulator_next;
  logic [3:0]                     digit_position_next;
  logic [1:0]                     sign_state_next;
  logic signed [epd_pkg::POS_W-1:0] held_x_next;

  // State as seen by this byte (after a command start clears it)
  logic                           seven_e, draw_e, abs_e, abort_e;
  logic [FW-1:0]                  frac_e;
  logic [2:0]                     tgt_e;
  logic [ACC_WIDTH-1:0]           acc_e;
  logic [3:0]                     dpos_e;
  logic [1:0]                     sign_e;
  logic signed [epd_pkg::POS_W-1:0] held_e;

  // Digit path
  logic                           term;
  logic [7:0]                     tbase;
  logic [7:0]                     dval;
  logic [6:0]                     sh;
  logic [ACC_WIDTH+7:0]           wide;
  logic [ACC_WIDTH:0]             sum;
  logic                           ovf;
  logic [ACC_WIDTH-1:0]           acc_new;
  logic [3:0]                     dpos_new;
  logic [1:0]                     sign_new;

  // Finished number
  logic [HALF_W-1:0]              half;
  logic                           neg;
  logic                           pen_bad;
  logic [FW-1:0]                  frac_val;
  logic [5:0]                     lsh, rsh;
  logic [30:0]                    lim_sh;
  logic [ACC_WIDTH-1:0]           acc_sh;
  logic [30:0]                    mag;
  logic signed [epd_pkg::POS_W-1:0] scaled;

  logic                           in_take;
  logic                           take;
  logic                           slot_load;
  logic [2:0]                     num_tgt;
  epd_pkg::cmd_t                  cmd_next;

  assign in_ready = !slot_valid || slot_ready;
  assign in_take  = in_valid && in_ready;

  // Command start clears the decode state before the byte is looked at
  always_comb begin
    seven_e = first ? 1'b0 : seven_bit_mode;
    frac_e  = first ? '0 : frac_shift;
    draw_e  = first ? pen_is_down : draw_flag;
    abs_e   = first ? 1'b0 : absolute_flag;
    abort_e = first ? 1'b0 : aborted;
    tgt_e   = first ? TGT_IDLE : number_target;
    acc_e   = first ? '0 : accumulator;
    dpos_e  = first ? '0 : digit_position;
    sign_e  = first ? SIGN_NONE : sign_state;
    held_e  = first ? '0 : held_x;
  end

  // One digit into the saturating accumulator
  always_comb begin
    if (seven_e) begin
      term  = (code_byte >= TERM7_LO) && (code_byte <= TERM7_HI);
      tbase = TERM7_LO;
      sh    = {1'b0, dpos_e, 2'b00} + {3'b000, dpos_e};
    end else begin
      term  = (code_byte >= TERM8_LO) && (code_byte <= TERM8_HI);
      tbase = TERM8_LO;
      sh    = {1'b0, dpos_e, 2'b00} + {2'b00, dpos_e, 1'b0};
    end
    dval     = term ? (code_byte - tbase) : (code_byte - DIGIT_LO);
    sign_new = sign_e;
    // sign rides in the low bit of the first digit
    if (sign_e == SIGN_NONE) begin
      sign_new = dval[0] ? SIGN_NEG : SIGN_POS;
      dval[0]  = 1'b0;
    end
    wide     = {{ACC_WIDTH{1'b0}}, dval} << sh;
    sum      = {1'b0, acc_e} + {1'b0, wide[ACC_WIDTH-1:0]};
    ovf      = (dval != 8'd0) &&
               ((sh >= 7'(ACC_WIDTH)) || (wide[ACC_WIDTH+7:ACC_WIDTH] != 8'd0) || sum[ACC_WIDTH]);
    acc_new  = ovf ? '1 : sum[ACC_WIDTH-1:0];
    dpos_new = (!term && (dpos_e != DPOS_MAX)) ? dpos_e + 4'd1 : dpos_e;
  end

  // Interpretations of a finished number: pen, fraction count, scaled coordinate
  always_comb begin
    half     = acc_new[ACC_WIDTH-1:1];
    neg      = (sign_new == SIGN_NEG);
    pen_bad  = neg || (half == '0) || (half > HALF_W'(pen_limit)) || (half > HALF_W'(PEN_MAX));
    frac_val = neg ? '0 :
               ((half > HALF_W'(MAX_FRAC_SHIFT)) ? FW'(MAX_FRAC_SHIFT) : half[FW-1:0]);

    // scale by 2^(COORD_FRAC - frac - 1), saturating the magnitude
    lsh    = 6'(FM1) - {1'b0, frac_e};
    rsh    = {1'b0, frac_e} - 6'(FM1);
    lim_sh = MAG_LIM >> lsh;
    acc_sh = acc_new >> rsh;
    if ({1'b0, frac_e} <= 6'(FM1)) begin
      mag = (acc_new > {{(ACC_WIDTH-31){1'b0}}, lim_sh}) ? MAG_LIM : (acc_new[30:0] << lsh);
    end else begin
      mag = (acc_sh[ACC_WIDTH-1:31] != '0) ? MAG_LIM : acc_sh[30:0];
    end
    scaled = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // Byte dispatch
  always_comb begin
    seven_bit_mode_next = seven_e;
    frac_shift_next     = frac_e;
    draw_flag_next      = draw_e;
    absolute_flag_next  = abs_e;
    aborted_next        = abort_e;
    number_target_next  = tgt_e;
    accumulator_next    = acc_e;
    digit_position_next = dpos_e;
    sign_state_next     = sign_e;
    held_x_next         = held_e;
    take                = 1'b0;
    num_tgt             = (tgt_e == TGT_IDLE) ? TGT_X : tgt_e;

    cmd_next          = '0;
    cmd_next.load     = first;
    cmd_next.start_x  = start_x;
    cmd_next.start_y  = start_y;
    cmd_next.absolute = abs_e;
    cmd_next.draw     = draw_e;
    slot_load         = first;

    if (!abort_e) begin
      if (tgt_e == TGT_IDLE) begin
        case (code_byte)
          CH_SEVEN: seven_bit_mode_next = 1'b1;
          CH_PEN:   number_target_next  = TGT_PEN;
          CH_MOVE:  draw_flag_next      = 1'b0;
          CH_FRAC:  number_target_next  = TGT_FRAC;
          CH_ABS:   absolute_flag_next  = 1'b1;
          default: begin
            if (code_byte >= DIGIT_LO) begin
              number_target_next = TGT_X;
              take               = 1'b1;
            end
          end
        endcase
      end else if (code_byte >= DIGIT_LO) begin
        take = 1'b1;
      end
    end

    if (take) begin
      accumulator_next    = acc_new;
      digit_position_next = dpos_new;
      sign_state_next     = sign_new;
      if (term) begin
        accumulator_next    = '0;
        digit_position_next = '0;
        sign_state_next     = SIGN_NONE;
        number_target_next  = TGT_IDLE;
        case (num_tgt)
          TGT_PEN: begin
            slot_load        = 1'b1;
            cmd_next.pen     = 1'b1;
            cmd_next.pen_bad = pen_bad;
            cmd_next.pen_idx = pen_bad ? 8'd0 : (half[7:0] - 8'd1);
            aborted_next     = pen_bad;
          end
          TGT_FRAC: frac_shift_next = frac_val;
          TGT_X: begin
            held_x_next        = scaled;
            number_target_next = TGT_Y;
          end
          default: begin
            // a relative zero pair only puts the pen down
            if (abs_e || (held_e != '0) || (mag != '0)) begin
              slot_load     = 1'b1;
              cmd_next.pair = 1'b1;
            end
            draw_flag_next     = 1'b1;
            absolute_flag_next = 1'b0;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seven_bit_mode <= 1'b0;
      frac_shift     <= '0;
      draw_flag      <= 1'b0;
      absolute_flag  <= 1'b0;
      aborted        <= 1'b0;
      number_target  <= TGT_IDLE;
      accumulator    <= '0;
      digit_position <= '0;
      sign_state     <= SIGN_NONE;
      held_x         <= '0;
    end else if (in_take) begin
      seven_bit_mode <= seven_bit_mode_next;
      frac_shift     <= frac_shift_next;
      draw_flag      <= draw_flag_next;
      absolute_flag  <= absolute_flag_next;
      aborted        <= aborted_next;
      number_target  <= number_target_next;
      accumulator    <= accumulator_next;
      digit_position <= digit_position_next;
      sign_state     <= sign_state_next;
      held_x         <= held_x_next;
    end
  end

  // Command register toward the transform
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (in_ready) begin
      slot_valid <= in_take && slot_load;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && slot_load) begin
      slot_cmd <= cmd_next;
      slot_x   <= held_e;
      slot_y   <= scaled;
    end
  end

  // No number in progress means the number state is clear
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (number_target == TGT_IDLE) |->
      (accumulator == '0) && (digit_position == '0) && (sign_state == SIGN_NONE))
    else $error("epd_decode: number state left over while idle");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    frac_shift <= FW'(MAX_FRAC_SHIFT))
    else $error("epd_decode: fraction count above its limit");

  a_abort_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_take && aborted && !first) |-> !slot_load)
    else $error("epd_decode: command issued after a bad pen");

endmodule

/* rtl/core/epd_affine.sv */
// Affine matrix stages: four 32x32 products, then the floor shift of each row sum.
// Two register stages with valid/ready flow control. Depends on epd_pkg.
`timescale 1ns / 1ps

module epd_affine #(
  parameter int COORD_FRAC = epd_pkg::COORD_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  epd_pkg::cmd_t                    in_cmd,
  input  logic signed [epd_pkg::POS_W-1:0] in_x,
  input  logic signed [epd_pkg::POS_W-1:0] in_y,
  input  epd_pkg::xform_t                  xform,
  output logic                             out_valid,
  input  logic                             out_ready,
  output epd_pkg::cmd_t                    out_cmd,
  output logic signed [64-COORD_FRAC:0]    out_qx,
  output logic signed [64-COORD_FRAC:0]    out_qy
);

  // Product stage
  logic                 prod_valid;
  epd_pkg::cmd_t        prod_cmd;
  logic signed [63:0]   pxx, pxy, pyx, pyy;
  logic signed [64:0]   sum_x, sum_y;
  logic                 prod_free, shift_free;

  assign shift_free = !out_valid || out_ready;
  assign prod_free  = !prod_valid || shift_free;
  assign in_ready   = prod_free;

  assign sum_x = {pxx[63], pxx} + {pxy[63], pxy};
  assign sum_y = {pyx[63], pyx} + {pyy[63], pyy};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (shift_free) out_valid  <= prod_valid;
      if (prod_free)  prod_valid <= in_valid;
    end
  end

  // Multiply, one register after the products
  always_ff @(posedge clk) begin
    if (prod_free && in_valid) begin
      prod_cmd <= in_cmd;
      pxx      <= xform.gain_xx * in_x;
      pxy      <= xform.gain_xy * in_y;
      pyx      <= xform.gain_yx * in_x;
      pyy      <= xform.gain_yy * in_y;
    end
  end

  // Row sum, dropping fraction bits rounds toward minus infinity
  always_ff @(posedge clk) begin
    if (shift_free && prod_valid) begin
      out_cmd <= prod_cmd;
      out_qx  <= sum_x[64:COORD_FRAC];
      out_qy  <= sum_y[64:COORD_FRAC];
    end
  end

endmodule

/* rtl/core/epd_emit.sv */
// Result stage: adds offset or pen base, saturates, tests the short-move threshold,
// keeps the pen position and holds the result register. Depends on epd_pkg.
`timescale 1ns / 1ps

module epd_emit #(
  parameter int COORD_FRAC = epd_pkg::COORD_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  epd_pkg::cmd_t                    in_cmd,
  input  logic signed [64-COORD_FRAC:0]    in_qx,
  input  logic signed [64-COORD_FRAC:0]    in_qy,
  input  epd_pkg::xform_t                  xform,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       kind,
  output logic signed [epd_pkg::POS_W-1:0] pos_x,
  output logic signed [epd_pkg::POS_W-1:0] pos_y,
  output logic [7:0]                       pen_index
);

  localparam int QW       = 65 - COORD_FRAC;
  localparam int MOVE_LIM = (1 << COORD_FRAC) / 1000;  // 0.001 in output units

  logic signed [epd_pkg::POS_W-1:0] pen_x, pen_y;
  logic signed [epd_pkg::POS_W-1:0] pen_x_next, pen_y_next;
  logic signed [epd_pkg::POS_W-1:0] base_px, base_py;  // pen before this pair
  logic signed [epd_pkg::POS_W-1:0] base_x, base_y;
  logic signed [epd_pkg::POS_W-1:0] tx, ty;
  logic [32:0]                      dx, dy, adx, ady;
  logic                             moved;
  logic                             res_emit;
  logic [1:0]                       kind_next;
  logic                             in_take;

  function automatic logic signed [31:0] sat32(input logic signed [QW:0] v);
    logic hi_ones, hi_zeros;
    hi_ones  = &v[QW:31];
    hi_zeros = ~|v[QW:31];
    if (hi_ones || hi_zeros) sat32 = v[31:0];
    else if (v[QW])          sat32 = {1'b1, 31'd0};
    else                     sat32 = {1'b0, {31{1'b1}}};
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  // Base position and transformed point
  always_comb begin
    base_px = in_cmd.load ? in_cmd.start_x : pen_x;
    base_py = in_cmd.load ? in_cmd.start_y : pen_y;
    base_x  = in_cmd.absolute ? xform.offset_x : base_px;
    base_y  = in_cmd.absolute ? xform.offset_y : base_py;
    tx = sat32({in_qx[QW-1], in_qx} + {{(QW-31){base_x[31]}}, base_x});
    ty = sat32({in_qy[QW-1], in_qy} + {{(QW-31){base_y[31]}}, base_y});
    dx  = {base_px[31], base_px} - {tx[31], tx};
    dy  = {base_py[31], base_py} - {ty[31], ty};
    adx = dx[32] ? -dx : dx;
    ady = dy[32] ? -dy : dy;
    moved = (adx > 33'(MOVE_LIM)) || (ady > 33'(MOVE_LIM));
  end

  // Result selection and pen tracking
  always_comb begin
    res_emit   = 1'b0;
    kind_next  = epd_pkg::KIND_MOVETO;
    pen_x_next = base_px;
    pen_y_next = base_py;
    if (in_cmd.pen) begin
      res_emit  = 1'b1;
      kind_next = in_cmd.pen_bad ? epd_pkg::KIND_BAD_PEN : epd_pkg::KIND_PEN;
    end else if (in_cmd.pair) begin
      res_emit   = !in_cmd.draw || moved;
      kind_next  = in_cmd.draw ? epd_pkg::KIND_LINETO : epd_pkg::KIND_MOVETO;
      pen_x_next = tx;
      pen_y_next = ty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (in_take) begin
      pen_x <= pen_x_next;
      pen_y <= pen_y_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_take && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res_emit) begin
      kind      <= kind_next;
      pos_x     <= in_cmd.pen ? '0 : tx;
      pos_y     <= in_cmd.pen ? '0 : ty;
      pen_index <= in_cmd.pen ? in_cmd.pen_idx : 8'd0;
    end
  end

  a_pen_no_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((kind == epd_pkg::KIND_PEN) || (kind == epd_pkg::KIND_BAD_PEN))) |->
      (pos_x == '0) && (pos_y == '0))
    else $error("epd_emit: pen result carries a position");

  a_move_no_pen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((kind == epd_pkg::KIND_MOVETO) || (kind == epd_pkg::KIND_LINETO))) |->
      (pen_index == 8'd0))
    else $error("epd_emit: move result carries a pen index");

endmodule

/* rtl/core/encoded_polyline_decoder.sv */
// Encoded polyline decoder: top level with the register file and the three pipeline parts.
// Depends on epd_pkg, epd_decode, epd_affine and epd_emit.
//
// Usage:
//   Input channel (in_valid/in_ready): one byte of an encoded polyline string per
//   transfer. first marks the opening byte of a command; start_x/start_y give the
//   pen position then and are ignored otherwise.
//   Output channel (out_valid/out_ready): zero or one result per byte, in byte order:
//   moveto, lineto, pen select or bad pen.
//   Registers: APB-style writes at byte address 4*index, pready is tied high.
//   Change them only while no byte is in flight.
// Timing:
//   One byte per clock sustained while the output is not stalled. A byte's result
//   passes through the decode register, product register and row-sum register into
//   the result register. The four 32x32 products are the deepest step.
// Reset:
//   Synchronous. Clears the decode state, pen position and all pipeline valids and
//   loads the register defaults (unit matrix, zero offset, eight pens, pen up).
// Stalls:
//   Each stage holds while the one after it is full; bytes that give no result
//   keep flowing, so in_ready drops only once the pipeline has backed up.
`timescale 1ns / 1ps

module encoded_polyline_decoder #(
  parameter int ACC_WIDTH      = epd_pkg::ACC_WIDTH_DEF,
  parameter int COORD_FRAC     = epd_pkg::COORD_FRAC_DEF,
  parameter int MAX_FRAC_SHIFT = epd_pkg::MAX_FRAC_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [4:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // byte input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       code_byte,
  input  logic                             first,
  input  logic signed [epd_pkg::POS_W-1:0] start_x,
  input  logic signed [epd_pkg::POS_W-1:0] start_y,
  // results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       kind,
  output logic signed [epd_pkg::POS_W-1:0] pos_x,
  output logic signed [epd_pkg::POS_W-1:0] pos_y,
  output logic [7:0]                       pen_index
);

  // Register indexes
  localparam logic [2:0] REG_GAIN_XX  = 3'd0;
  localparam logic [2:0] REG_GAIN_XY  = 3'd1;
  localparam logic [2:0] REG_GAIN_YX  = 3'd2;
  localparam logic [2:0] REG_GAIN_YY  = 3'd3;
  localparam logic [2:0] REG_OFFSET_X = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y = 3'd5;
  localparam logic [2:0] REG_PEN_LIM  = 3'd6;
  localparam logic [2:0] REG_PEN_DOWN = 3'd7;

  localparam logic [31:0] GAIN_ONE = 32'h0001_0000;

  epd_pkg::xform_t                  xform;
  logic [8:0]                       pen_limit;
  logic                             pen_is_down;
  logic                             cfg_write;
  logic [2:0]                       cfg_idx;

  logic                             dec_valid, dec_ready;
  epd_pkg::cmd_t                    dec_cmd;
  logic signed [epd_pkg::POS_W-1:0] dec_x, dec_y;

  logic                             aff_valid, aff_ready;
  epd_pkg::cmd_t                    aff_cmd;
  logic signed [64-COORD_FRAC:0]    aff_qx, aff_qy;

  assign pready    = 1'b1;
  assign cfg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      xform.gain_xx  <= GAIN_ONE;
      xform.gain_xy  <= '0;
      xform.gain_yx  <= '0;
      xform.gain_yy  <= GAIN_ONE;
      xform.offset_x <= '0;
      xform.offset_y <= '0;
      pen_limit      <= 9'd8;
      pen_is_down    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_GAIN_XX:  xform.gain_xx  <= pwdata;
        REG_GAIN_XY:  xform.gain_xy  <= pwdata;
        REG_GAIN_YX:  xform.gain_yx  <= pwdata;
        REG_GAIN_YY:  xform.gain_yy  <= pwdata;
        REG_OFFSET_X: xform.offset_x <= pwdata;
        REG_OFFSET_Y: xform.offset_y <= pwdata;
        REG_PEN_LIM:  pen_limit      <= pwdata[8:0];
        REG_PEN_DOWN: pen_is_down    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_GAIN_XX:  prdata = xform.gain_xx;
      REG_GAIN_XY:  prdata = xform.gain_xy;
      REG_GAIN_YX:  prdata = xform.gain_yx;
      REG_GAIN_YY:  prdata = xform.gain_yy;
      REG_OFFSET_X: prdata = xform.offset_x;
      REG_OFFSET_Y: prdata = xform.offset_y;
      REG_PEN_LIM:  prdata = {23'd0, pen_limit};
      REG_PEN_DOWN: prdata = {31'd0, pen_is_down};
      default:      prdata = '0;
    endcase
  end

  epd_decode #(
    .ACC_WIDTH      (ACC_WIDTH),
    .COORD_FRAC     (COORD_FRAC),
    .MAX_FRAC_SHIFT (MAX_FRAC_SHIFT)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .code_byte   (code_byte),
    .first       (first),
    .start_x     (start_x),
    .start_y     (start_y),
    .pen_limit   (pen_limit),
    .pen_is_down (pen_is_down),
    .slot_valid  (dec_valid),
    .slot_ready  (dec_ready),
    .slot_cmd    (dec_cmd),
    .slot_x      (dec_x),
    .slot_y      (dec_y)
  );

  epd_affine #(
    .COORD_FRAC (COORD_FRAC)
  ) u_affine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_cmd    (dec_cmd),
    .in_x      (dec_x),
    .in_y      (dec_y),
    .xform     (xform),
    .out_valid (aff_valid),
    .out_ready (aff_ready),
    .out_cmd   (aff_cmd),
    .out_qx    (aff_qx),
    .out_qy    (aff_qy)
  );

  epd_emit #(
    .COORD_FRAC (COORD_FRAC)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (aff_valid),
    .in_ready  (aff_ready),
    .in_cmd    (aff_cmd),
    .in_qx     (aff_qx),
    .in_qy     (aff_qy),
    .xform     (xform),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pen_index (pen_index)
  );

endmodule
